// ===== hdl/ts2e_pkg.sv =====
package ts2e_pkg;

    localparam int YEAR_W  = 14;
    localparam int FLD_W   = 7;
    localparam int FRAC_W  = 20;
    localparam int EPOCH_W = 39;
    localparam int CNT_W   = 3;
    localparam int Q_DEPTH = 2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_UZ    = 8'h5a;
    localparam logic [7:0] CH_LZ    = 8'h7a;

    localparam logic [CNT_W-1:0] YEAR_DIGITS  = 3'd4;
    localparam logic [CNT_W-1:0] FIELD_DIGITS = 3'd2;
    localparam logic [CNT_W-1:0] FRAC_DIGITS  = 3'd6;

    localparam logic [FLD_W-1:0] MONTH_MAX  = 7'd12;
    localparam logic [FLD_W-1:0] DAY_MAX    = 7'd31;
    localparam logic [FLD_W-1:0] HOUR_MAX   = 7'd23;
    localparam logic [FLD_W-1:0] MINUTE_MAX = 7'd59;
    localparam logic [FLD_W-1:0] SECOND_MAX = 7'd60;

    // x / 100 == (x * 5243) >> 19 for x below 43690
    localparam logic [12:0] DIV100_MUL  = 13'd5243;
    localparam int          DIV100_SH   = 19;
    localparam logic [16:0] SEC_PER_DAY = 17'd86400;
    // 719468 + 146097 (epoch offset plus the extra era added to the year)
    localparam logic [19:0] DAY_BIAS    = 20'd865565;

    typedef enum logic [10:0] {
        PH_YEAR       = 11'b000_0000_0001,
        PH_MONTH      = 11'b000_0000_0010,
        PH_DAY        = 11'b000_0000_0100,
        PH_HOUR       = 11'b000_0000_1000,
        PH_MINUTE     = 11'b000_0001_0000,
        PH_SECOND     = 11'b000_0010_0000,
        PH_FRAC_FIRST = 11'b000_0100_0000,
        PH_FRAC       = 11'b000_1000_0000,
        PH_ZONE_HOUR  = 11'b001_0000_0000,
        PH_ZONE_MIN   = 11'b010_0000_0000,
        PH_DONE       = 11'b100_0000_0000
    } t_phase;

    typedef struct packed {
        logic              ok;
        logic [YEAR_W-1:0] year;
        logic [FLD_W-1:0]  month;
        logic [FLD_W-1:0]  day;
        logic [FLD_W-1:0]  hour;
        logic [FLD_W-1:0]  minute;
        logic [FLD_W-1:0]  second;
        logic [FRAC_W-1:0] frac;
        logic              zneg;
        logic [FLD_W-1:0]  zh;
        logic [FLD_W-1:0]  zm;
    } t_req;

    function automatic logic [16:0] frac_scale(input logic [CNT_W-1:0] place);
        logic [16:0] s;
        case (place)
            3'd0:    s = 17'd100000;
            3'd1:    s = 17'd10000;
            3'd2:    s = 17'd1000;
            3'd3:    s = 17'd100;
            3'd4:    s = 17'd10;
            3'd5:    s = 17'd1;
            default: s = 17'd0;
        endcase
        return s;
    endfunction

    // days from march 1 to the first of the month
    function automatic logic [8:0] month_days(input logic [FLD_W-1:0] m);
        logic [8:0] d;
        case (m)
            7'd3:    d = 9'd0;
            7'd4:    d = 9'd31;
            7'd5:    d = 9'd61;
            7'd6:    d = 9'd92;
            7'd7:    d = 9'd122;
            7'd8:    d = 9'd153;
            7'd9:    d = 9'd184;
            7'd10:   d = 9'd214;
            7'd11:   d = 9'd245;
            7'd12:   d = 9'd275;
            7'd1:    d = 9'd306;
            7'd2:    d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== hdl/ts2e_front.sv =====
module ts2e_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [7:0]      i_char_code,
    input  logic            i_is_last,
    input  logic            i_q_full,
    output logic            o_push,
    output ts2e_pkg::t_req  o_req
);
    import ts2e_pkg::*;

    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [YEAR_W-1:0]  r_year, n_year;
    logic [FLD_W-1:0]   r_month, n_month, r_day, n_day, r_hour, n_hour;
    logic [FLD_W-1:0]   r_minute, n_minute, r_second, n_second;
    logic [FLD_W-1:0]   r_zh, n_zh, r_zm, n_zm;
    logic [FRAC_W-1:0]  r_frac, n_frac;
    logic [CNT_W-1:0]   r_place, n_place;
    logic               r_zneg, n_zneg;
    logic               r_fail, n_fail;

    logic               w_take;
    logic               w_dig;
    logic [3:0]         w_d;
    logic [YEAR_W-1:0]  w_cur;
    logic [YEAR_W-1:0]  w_acc;
    logic [7:0]         w_sep;
    t_phase             w_next;
    logic [CNT_W-1:0]   w_maxd;
    logic               w_zone_z;
    logic               w_zone_sign;
    logic               w_ok;

    assign o_in_ready  = !i_q_full;
    assign w_take      = i_in_valid && o_in_ready;
    assign o_push      = w_take && i_is_last;
    assign w_dig       = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
    assign w_d         = i_char_code[3:0];
    assign w_acc       = YEAR_W'(w_cur * 4'd10) + YEAR_W'(w_d);
    assign w_zone_z    = (i_char_code == CH_UZ) || (i_char_code == CH_LZ);
    assign w_zone_sign = (i_char_code == CH_PLUS) || (i_char_code == CH_DASH);

    always_comb begin
        w_cur  = '0;
        w_sep  = CH_DASH;
        w_next = PH_DONE;
        w_maxd = FIELD_DIGITS;
        case (r_phase)
            PH_YEAR: begin
                w_cur  = r_year;
                w_next = PH_MONTH;
                w_maxd = YEAR_DIGITS;
            end
            PH_MONTH: begin
                w_cur  = YEAR_W'(r_month);
                w_next = PH_DAY;
            end
            PH_DAY: begin
                w_cur  = YEAR_W'(r_day);
                w_sep  = CH_T;
                w_next = PH_HOUR;
            end
            PH_HOUR: begin
                w_cur  = YEAR_W'(r_hour);
                w_sep  = CH_COLON;
                w_next = PH_MINUTE;
            end
            PH_MINUTE: begin
                w_cur  = YEAR_W'(r_minute);
                w_sep  = CH_COLON;
                w_next = PH_SECOND;
            end
            PH_SECOND: begin
                w_cur  = YEAR_W'(r_second);
            end
            PH_ZONE_HOUR: begin
                w_cur  = YEAR_W'(r_zh);
                w_sep  = CH_COLON;
                w_next = PH_ZONE_MIN;
            end
            PH_ZONE_MIN: begin
                w_cur  = YEAR_W'(r_zm);
            end
            default: ;
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_frac   = r_frac;
        n_place  = r_place;
        n_zneg   = r_zneg;
        n_zh     = r_zh;
        n_zm     = r_zm;
        n_fail   = r_fail;

        if (w_take && !r_fail) begin
            if (w_dig && !(r_phase == PH_FRAC_FIRST || r_phase == PH_FRAC)
                    && r_phase != PH_DONE) begin
                if (r_cnt >= w_maxd) begin
                    n_fail = 1'b1;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                    case (r_phase)
                        PH_YEAR:      n_year   = w_acc;
                        PH_MONTH:     n_month  = w_acc[FLD_W-1:0];
                        PH_DAY:       n_day    = w_acc[FLD_W-1:0];
                        PH_HOUR:      n_hour   = w_acc[FLD_W-1:0];
                        PH_MINUTE:    n_minute = w_acc[FLD_W-1:0];
                        PH_SECOND:    n_second = w_acc[FLD_W-1:0];
                        PH_ZONE_HOUR: n_zh     = w_acc[FLD_W-1:0];
                        PH_ZONE_MIN:  n_zm     = w_acc[FLD_W-1:0];
                        default: ;
                    endcase
                end
            end else begin
                case (r_phase)
                    PH_YEAR, PH_MONTH, PH_DAY, PH_HOUR, PH_MINUTE, PH_ZONE_HOUR: begin
                        if (i_char_code == w_sep && r_cnt != '0) begin
                            n_phase = w_next;
                            n_cnt   = '0;
                        end else begin
                            n_fail = 1'b1;
                        end
                    end
                    PH_SECOND: begin
                        if (r_cnt == '0) begin
                            n_fail = 1'b1;
                        end else if (i_char_code == CH_DOT || i_char_code == CH_COMMA) begin
                            n_phase = PH_FRAC_FIRST;
                            n_cnt   = '0;
                        end else if (w_zone_z) begin
                            n_phase = PH_DONE;
                            n_cnt   = '0;
                        end else if (w_zone_sign) begin
                            n_zneg  = (i_char_code == CH_DASH);
                            n_phase = PH_ZONE_HOUR;
                            n_cnt   = '0;
                        end else begin
                            n_fail = 1'b1;
                        end
                    end
                    PH_FRAC_FIRST, PH_FRAC: begin
                        if (w_dig) begin
                            if (r_place < FRAC_DIGITS) begin
                                n_frac  = r_frac + FRAC_W'(w_d * frac_scale(r_place));
                                n_place = r_place + 3'd1;
                            end
                            n_phase = PH_FRAC;
                        end else if (r_phase == PH_FRAC && w_zone_z) begin
                            n_phase = PH_DONE;
                            n_cnt   = '0;
                        end else if (r_phase == PH_FRAC && w_zone_sign) begin
                            n_zneg  = (i_char_code == CH_DASH);
                            n_phase = PH_ZONE_HOUR;
                            n_cnt   = '0;
                        end else begin
                            n_fail = 1'b1;
                        end
                    end
                    default: n_fail = 1'b1;
                endcase
            end
        end

        w_ok = !n_fail
            && (n_phase == PH_DONE || (n_phase == PH_ZONE_MIN && n_cnt != '0))
            && n_month >= 7'd1 && n_month <= MONTH_MAX
            && n_day >= 7'd1 && n_day <= DAY_MAX
            && n_hour <= HOUR_MAX && n_minute <= MINUTE_MAX && n_second <= SECOND_MAX
            && n_zh <= HOUR_MAX && n_zm <= MINUTE_MAX;

        o_req.ok     = w_ok;
        o_req.year   = n_year;
        o_req.month  = n_month;
        o_req.day    = n_day;
        o_req.hour   = n_hour;
        o_req.minute = n_minute;
        o_req.second = n_second;
        o_req.frac   = n_frac;
        o_req.zneg   = n_zneg;
        o_req.zh     = n_zh;
        o_req.zm     = n_zm;

        if (o_push) begin
            n_phase  = PH_YEAR;
            n_cnt    = '0;
            n_year   = '0;
            n_month  = '0;
            n_day    = '0;
            n_hour   = '0;
            n_minute = '0;
            n_second = '0;
            n_frac   = '0;
            n_place  = '0;
            n_zneg   = 1'b0;
            n_zh     = '0;
            n_zm     = '0;
            n_fail   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_YEAR;
            r_cnt    <= '0;
            r_year   <= '0;
            r_month  <= '0;
            r_day    <= '0;
            r_hour   <= '0;
            r_minute <= '0;
            r_second <= '0;
            r_frac   <= '0;
            r_place  <= '0;
            r_zneg   <= 1'b0;
            r_zh     <= '0;
            r_zm     <= '0;
            r_fail   <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_year   <= n_year;
            r_month  <= n_month;
            r_day    <= n_day;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
            r_frac   <= n_frac;
            r_place  <= n_place;
            r_zneg   <= n_zneg;
            r_zh     <= n_zh;
            r_zm     <= n_zm;
            r_fail   <= n_fail;
        end
    end

endmodule

// ===== hdl/ts2e_queue.sv =====
module ts2e_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ts2e_pkg::t_req  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output ts2e_pkg::t_req  o_data,
    output logic            o_empty
);
    import ts2e_pkg::*;

    localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_req            r_mem [Q_DEPTH];
    logic [AW-1:0]   r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == CW'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== hdl/ts2e_back.sv =====
module ts2e_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_empty,
    output logic                                 o_pop,
    input  ts2e_pkg::t_req                       i_req,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_valid_res,
    output logic signed [ts2e_pkg::EPOCH_W-1:0]  o_epoch_seconds,
    output logic        [ts2e_pkg::FRAC_W-1:0]   o_micro_seconds
);
    import ts2e_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MUL   = 5'b00010,
        ST_DAYS  = 5'b00100,
        ST_SCALE = 5'b01000,
        ST_SUM   = 5'b10000
    } t_state;

    t_state                    r_st, n_st;
    logic                      r_out_valid, n_out_valid;
    logic                      w_load;

    logic                      r_ok;
    logic [YEAR_W-1:0]         r_yy;
    logic [8:0]                r_doy;
    logic [FLD_W-1:0]          r_hour, r_minute, r_second, r_zh, r_zm;
    logic                      r_zneg;
    logic [FRAC_W-1:0]         r_frac;

    logic [21:0]               r_p365;
    logic [26:0]               r_p100;
    logic [24:0]               r_p400;
    logic [18:0]               r_hs;
    logic [12:0]               r_ms;
    logic [18:0]               r_zs;

    logic signed [24:0]        r_days;
    logic signed [20:0]        r_tod;
    logic signed [EPOCH_W-1:0] r_dsec;

    logic [24:0]               w_days;
    logic [20:0]               w_pos;

    logic                      r_res;
    logic signed [EPOCH_W-1:0] r_epoch;
    logic [FRAC_W-1:0]         r_micro;

    assign o_pop           = (r_st == ST_IDLE) && !i_empty;
    assign w_load          = (r_st == ST_SUM) && (!r_out_valid || i_out_ready);
    assign o_out_valid     = r_out_valid;
    assign o_valid_res     = r_res;
    assign o_epoch_seconds = r_epoch;
    assign o_micro_seconds = r_micro;

    assign w_days = 25'(r_p365) + 25'(r_yy[YEAR_W-1:2])
                  - 25'(r_p100[26:DIV100_SH]) + 25'(r_p400[24:DIV100_SH])
                  + 25'(r_doy) - 25'(DAY_BIAS);
    assign w_pos  = 21'(r_hs) + 21'(r_ms);

    always_comb begin
        n_st        = r_st;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_st)
            ST_IDLE:  if (!i_empty) n_st = ST_MUL;
            ST_MUL:   n_st = ST_DAYS;
            ST_DAYS:  n_st = ST_SCALE;
            ST_SCALE: n_st = ST_SUM;
            ST_SUM: begin
                if (w_load) begin
                    n_st        = ST_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default:  n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ok     <= i_req.ok;
            r_yy     <= i_req.year + YEAR_W'(400)
                        - YEAR_W'(i_req.month <= 7'd2);
            r_doy    <= month_days(i_req.month) + 9'(i_req.day) - 9'd1;
            r_hour   <= i_req.hour;
            r_minute <= i_req.minute;
            r_second <= i_req.second;
            r_zh     <= i_req.zh;
            r_zm     <= i_req.zm;
            r_zneg   <= i_req.zneg;
            r_frac   <= i_req.frac;
        end
        if (r_st == ST_MUL) begin
            r_p365 <= 22'(r_yy * 9'd365);
            r_p100 <= 27'(r_yy * DIV100_MUL);
            r_p400 <= 25'(r_yy[YEAR_W-1:2] * DIV100_MUL);
            r_hs   <= 19'(r_hour * 12'd3600);
            r_ms   <= 13'(r_minute * 6'd60) + 13'(r_second);
            r_zs   <= 19'(r_zh * 12'd3600) + 19'(r_zm * 6'd60);
        end
        if (r_st == ST_DAYS) begin
            r_days <= $signed(w_days);
            r_tod  <= r_zneg ? $signed(w_pos + 21'(r_zs)) : $signed(w_pos - 21'(r_zs));
        end
        if (r_st == ST_SCALE) begin
            r_dsec <= EPOCH_W'(r_days * $signed({1'b0, SEC_PER_DAY}));
        end
        if (w_load) begin
            r_res   <= r_ok;
            r_epoch <= r_ok ? r_dsec + EPOCH_W'(r_tod) : '0;
            r_micro <= r_ok ? r_frac : '0;
        end
    end

endmodule

// ===== hdl/timestamp_text_to_epoch.sv =====
// channel | valid      | ready       | payload
// in      | i_in_valid | o_in_ready  | i_char_code, i_is_last
// out     | o_out_valid| i_out_ready | o_valid_res, o_epoch_seconds, o_micro_seconds
//
// characters are taken one per cycle unless stalled; the front holds no wait states
// a string's last character queues its fields; the epoch unit then takes
// five steps per string (pop, products, day count, day scaling, final sum)
// the queue holds two strings; the front stalls only while it is full
// synchronous active-low reset returns the parser to the first year digit
// a waiting result in the output register does not block the epoch unit start
module timestamp_text_to_epoch (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [7:0]                           i_char_code,
    input  logic                                 i_is_last,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_valid_res,
    output logic signed [ts2e_pkg::EPOCH_W-1:0]  o_epoch_seconds,
    output logic        [ts2e_pkg::FRAC_W-1:0]   o_micro_seconds
);
    import ts2e_pkg::*;

    logic w_push, w_full, w_pop, w_empty;
    t_req w_req_in, w_req_out;

    ts2e_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_char_code (i_char_code),
        .i_is_last   (i_is_last),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_req       (w_req_in)
    );

    ts2e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_req_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_req_out),
        .o_empty (w_empty)
    );

    ts2e_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (w_empty),
        .o_pop           (w_pop),
        .i_req           (w_req_out),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_valid_res     (o_valid_res),
        .o_epoch_seconds (o_epoch_seconds),
        .o_micro_seconds (o_micro_seconds)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("pop from empty queue");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_valid_res) |-> (o_epoch_seconds == '0 && o_micro_seconds == '0))
        else $error("failed beat carries nonzero fields");

endmodule
